FILE: hw/rtl/dna_pkg.sv
package dna_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD          = 32;
    localparam int QBITS         = 32;

    localparam logic [3:0] CMD_ADD  = 4'd0;
    localparam logic [3:0] CMD_SUB  = 4'd1;
    localparam logic [3:0] CMD_MUL  = 4'd2;
    localparam logic [3:0] CMD_DIV  = 4'd3;
    localparam logic [3:0] CMD_NEG  = 4'd4;
    localparam logic [3:0] CMD_CONJ = 4'd5;
    localparam logic [3:0] CMD_INV  = 4'd6;
    localparam logic [3:0] CMD_MAG  = 4'd7;
    localparam logic [3:0] CMD_SQR  = 4'd8;

    // One divider lane: partial remainder, divisor, low dividend bits, quotient
    typedef struct packed {
        logic [62:0] rem;
        logic [62:0] dvsr;
        logic [31:0] xlo;
        logic [31:0] quo;
        logic        ovf;
        logic        neg;
    } lane_t;

    // Results that bypass the divider
    typedef struct packed {
        logic        use_div;
        logic        dz;
        logic        sat;
        logic        eq;
        logic [31:0] rr;
        logic [31:0] rd;
    } side_t;

    typedef struct packed {
        lane_t re;
        lane_t du;
        side_t side;
    } cell_t;

    // Clamp to 32-bit signed range, flag in the top bit
    function automatic logic [32:0] sat32(logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic signed [65:0] to_signed(logic neg, logic [64:0] mag);
        logic signed [65:0] s;
        s = $signed({1'b0, mag});
        return neg ? -s : s;
    endfunction

endpackage

FILE: hw/rtl/dna_front.sv
module dna_front #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          command,
    input  logic signed [31:0]  a_real,
    input  logic signed [31:0]  a_dual,
    input  logic signed [31:0]  b_real,
    input  logic signed [31:0]  b_dual,
    output logic                out_valid,
    input  logic                out_ready,
    output dna_pkg::cell_t      out_data
);

    localparam int SH = 32 - FRAC_BITS;

    function automatic logic [64:0] abs66(logic signed [65:0] v);
        return (v < 0) ? 65'(-v) : 65'(v);
    endfunction

    logic               a_vld_reg, b_vld_reg, c_vld_reg;
    logic               rdy_a, rdy_b, rdy_c;
    logic [3:0]         cmd_a_reg;
    logic signed [31:0] ar_a_reg, ad_a_reg, br_a_reg, bd_a_reg;
    logic signed [63:0] p1_a_reg, p2_a_reg, p3_a_reg, p4_a_reg;
    logic signed [31:0] sq_src;

    assign rdy_c    = !c_vld_reg || out_ready;
    assign rdy_b    = !b_vld_reg || rdy_c;
    assign rdy_a    = !a_vld_reg || rdy_b;
    assign in_ready = rdy_a;
    assign sq_src   = (command == dna_pkg::CMD_DIV) ? b_real : a_real;

    // Stage A: products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (rdy_a) begin
            a_vld_reg <= in_valid;
        end
        if (rdy_a && in_valid) begin
            cmd_a_reg <= command;
            ar_a_reg  <= a_real;
            ad_a_reg  <= a_dual;
            br_a_reg  <= b_real;
            bd_a_reg  <= b_dual;
            p1_a_reg  <= a_real * b_real;
            p2_a_reg  <= a_dual * b_real;
            p3_a_reg  <= a_real * b_dual;
            p4_a_reg  <= sq_src * sq_src;
        end
    end

    // Stage B: direct results and divider operands
    dna_pkg::side_t side_next, side_b_reg;
    logic [63:0]    mre_next, mdu_next, mre_b_reg, mdu_b_reg;
    logic [62:0]    dre_next, ddu_next, dre_b_reg, ddu_b_reg;
    logic           nre_next, ndu_next, nre_b_reg, ndu_b_reg;

    always_comb begin
        logic signed [65:0] vr, vd, spp, dpp;
        logic [32:0]        sr, sd;
        logic [64:0]        are, aad, abr, adp;
        logic               is_div, is_inv;
        are    = abs66(66'(ar_a_reg));
        aad    = abs66(66'(ad_a_reg));
        abr    = abs66(66'(br_a_reg));
        spp    = 66'(p2_a_reg) + 66'(p3_a_reg);
        dpp    = 66'(p2_a_reg) - 66'(p3_a_reg);
        adp    = abs66(dpp);
        vr     = '0;
        vd     = '0;
        is_div = (cmd_a_reg == dna_pkg::CMD_DIV);
        is_inv = (cmd_a_reg == dna_pkg::CMD_INV);
        unique case (cmd_a_reg)
            dna_pkg::CMD_ADD: begin
                vr = 66'(ar_a_reg) + 66'(br_a_reg);
                vd = 66'(ad_a_reg) + 66'(bd_a_reg);
            end
            dna_pkg::CMD_SUB: begin
                vr = 66'(ar_a_reg) - 66'(br_a_reg);
                vd = 66'(ad_a_reg) - 66'(bd_a_reg);
            end
            dna_pkg::CMD_MUL: begin
                vr = dna_pkg::to_signed(p1_a_reg < 0, abs66(66'(p1_a_reg)) >> FRAC_BITS);
                vd = dna_pkg::to_signed(spp < 0, abs66(spp) >> FRAC_BITS);
            end
            dna_pkg::CMD_NEG: begin
                vr = -66'(ar_a_reg);
                vd = -66'(ad_a_reg);
            end
            dna_pkg::CMD_CONJ: begin
                vr = 66'(ar_a_reg);
                vd = -66'(ad_a_reg);
            end
            dna_pkg::CMD_MAG: begin
                vr = $signed({1'b0, are});
            end
            dna_pkg::CMD_SQR: begin
                vr = $signed({1'b0, abs66(66'(p4_a_reg)) >> FRAC_BITS});
            end
            default: begin
                vr = '0;
                vd = '0;
            end
        endcase
        sr = dna_pkg::sat32(vr);
        sd = dna_pkg::sat32(vd);
        side_next.dz      = (is_div && br_a_reg == 0) || (is_inv && ar_a_reg == 0);
        side_next.use_div = (is_div || is_inv) && !side_next.dz;
        side_next.sat     = sr[32] | sd[32];
        side_next.eq      = (ar_a_reg == br_a_reg) && (ad_a_reg == bd_a_reg);
        side_next.rr      = sr[31:0];
        side_next.rd      = sd[31:0];
        ddu_next          = p4_a_reg[62:0];
        if (is_div) begin
            mre_next = are[63:0];
            dre_next = abr[62:0];
            nre_next = (ar_a_reg < 0) != (br_a_reg < 0);
            mdu_next = adp[63:0];
            ndu_next = dpp < 0;
        end else begin
            mre_next = 64'(1) << FRAC_BITS;
            dre_next = are[62:0];
            nre_next = ar_a_reg < 0;
            mdu_next = aad[63:0] << FRAC_BITS;
            ndu_next = ad_a_reg > 0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (rdy_b) begin
            b_vld_reg <= a_vld_reg;
        end
        if (rdy_b && a_vld_reg) begin
            side_b_reg <= side_next;
            mre_b_reg  <= mre_next;
            mdu_b_reg  <= mdu_next;
            dre_b_reg  <= dre_next;
            ddu_b_reg  <= ddu_next;
            nre_b_reg  <= nre_next;
            ndu_b_reg  <= ndu_next;
        end
    end

    // Stage C: overflow check and first partial remainder
    function automatic dna_pkg::lane_t setup(logic [63:0] m, logic [62:0] d, logic neg);
        dna_pkg::lane_t l;
        logic [63:0]    r0;
        r0     = m >> SH;
        l.ovf  = r0 >= {1'b0, d};
        l.rem  = l.ovf ? '0 : r0[62:0];
        l.dvsr = d;
        l.xlo  = 32'(m << FRAC_BITS);
        l.quo  = '0;
        l.neg  = neg;
        return l;
    endfunction

    dna_pkg::cell_t c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (rdy_c) begin
            c_vld_reg <= b_vld_reg;
        end
        if (rdy_c && b_vld_reg) begin
            c_reg.re   <= setup(mre_b_reg, dre_b_reg, nre_b_reg);
            c_reg.du   <= setup(mdu_b_reg, ddu_b_reg, ndu_b_reg);
            c_reg.side <= side_b_reg;
        end
    end

    assign out_valid = c_vld_reg;
    assign out_data  = c_reg;

endmodule

FILE: hw/rtl/dna_div_cell.sv
module dna_div_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  dna_pkg::cell_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dna_pkg::cell_t out_data
);

    // One restoring step: shift in a dividend bit, subtract if it fits
    function automatic dna_pkg::lane_t step(dna_pkg::lane_t l);
        dna_pkg::lane_t n;
        logic [63:0]    t;
        logic           fit;
        t      = {l.rem, l.xlo[31]};
        fit    = t >= {1'b0, l.dvsr};
        n      = l;
        n.rem  = fit ? 63'(t - {1'b0, l.dvsr}) : t[62:0];
        n.xlo  = {l.xlo[30:0], 1'b0};
        n.quo  = {l.quo[30:0], fit};
        return n;
    endfunction

    logic           vld_reg;
    dna_pkg::cell_t data_reg;

    assign in_ready = !vld_reg || out_ready;

    // Advance one quotient bit per cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg.re   <= step(in_data.re);
            data_reg.du   <= step(in_data.du);
            data_reg.side <= in_data.side;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

FILE: hw/rtl/dna_back.sv
module dna_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  dna_pkg::cell_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    res_real,
    output logic [31:0]    res_dual,
    output logic           div_zero,
    output logic           saturated,
    output logic           equal
);

    // Apply sign and clamp a divider quotient
    function automatic logic [32:0] finish(dna_pkg::lane_t l);
        logic [32:0] r;
        if (l.ovf) begin
            r = {1'b1, l.neg ? 32'h8000_0000 : 32'h7fff_ffff};
        end else begin
            r = dna_pkg::sat32(dna_pkg::to_signed(l.neg, 65'(l.quo)));
        end
        return r;
    endfunction

    logic        vld_reg;
    logic [31:0] rr_reg, rd_reg;
    logic        dz_reg, sat_reg, eq_reg;
    logic [32:0] fr, fd;

    assign in_ready = !vld_reg || out_ready;
    assign fr       = finish(in_data.re);
    assign fd       = finish(in_data.du);

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            dz_reg <= in_data.side.dz;
            eq_reg <= in_data.side.eq;
            if (in_data.side.use_div) begin
                rr_reg  <= fr[31:0];
                rd_reg  <= fd[31:0];
                sat_reg <= fr[32] | fd[32];
            end else begin
                rr_reg  <= in_data.side.rr;
                rd_reg  <= in_data.side.rd;
                sat_reg <= in_data.side.sat;
            end
        end
    end

    assign out_valid = vld_reg;
    assign res_real  = rr_reg;
    assign res_dual  = rd_reg;
    assign div_zero  = dz_reg;
    assign saturated = sat_reg;
    assign equal     = eq_reg;

endmodule

FILE: hw/rtl/dual_number_alu.sv
// Pipeline: 36 register stages between the input accept and m_tvalid:
//   3 front stages, 32 divider cells producing one quotient bit each, 1 output register.
// Throughput: one item per cycle while the output is not stalled; every stage advances
//   whenever the next one is empty or moving, so bubbles collapse under output stalls.
// Reset: synchronous active-low aresetn clears all stage valid bits.
module dual_number_alu #(
    parameter int FRAC_BITS = dna_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[3:0], a_real[35:4], a_dual[67:36], b_real[99:68], b_dual[131:100]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_real[31:0], res_dual[63:32]
    output logic [63:0]  m_tdata,
    // div_zero[0], saturated[1], equal[2]
    output logic [2:0]   m_tuser
);

    localparam int N = dna_pkg::QBITS;

    dna_pkg::cell_t chain_d [0:N];
    logic           chain_v [0:N];
    logic           chain_r [0:N];
    logic [31:0]    res_real, res_dual;

    dna_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .command  (s_tdata[3:0]),
        .a_real   ($signed(s_tdata[35:4])),
        .a_dual   ($signed(s_tdata[67:36])),
        .b_real   ($signed(s_tdata[99:68])),
        .b_dual   ($signed(s_tdata[131:100])),
        .out_valid(chain_v[0]),
        .out_ready(chain_r[0]),
        .out_data (chain_d[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar i = 0; i < N; i++) begin : g_cell
        dna_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (chain_v[i]),
            .in_ready (chain_r[i]),
            .in_data  (chain_d[i]),
            .out_valid(chain_v[i+1]),
            .out_ready(chain_r[i+1]),
            .out_data (chain_d[i+1])
        );
    end

    dna_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chain_v[N]),
        .in_ready (chain_r[N]),
        .in_data  (chain_d[N]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .res_real (res_real),
        .res_dual (res_dual),
        .div_zero (m_tuser[0]),
        .saturated(m_tuser[1]),
        .equal    (m_tuser[2])
    );

    assign m_tdata = {res_dual, res_real};

    // A zero divisor gives a zero, unclamped result
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0)
        else $error("div_zero result not zero");

    a_dz_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("div_zero with saturated");

    // An empty output register always takes from the chain
    a_back_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> chain_r[N])
        else $error("output stage empty but not ready");

endmodule

FILE: tb/dna_checker.sv
// Watches both channels of the dual number ALU, predicts every result from
// the accepted input items and compares the results as they leave.
module dna_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [135:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           results_seen
);

    localparam int FB = dna_pkg::FRAC_BITS_DEF;

    typedef struct packed {
        logic [31:0] rr;
        logic [31:0] rd;
        logic        dz;
        logic        sat;
        logic        eq;
    } dual_res_t;

    dual_res_t expected_q[$];

    // Clamp a sign-magnitude value to 32 bits; flag in the top bit
    function automatic logic [32:0] clamp_part(logic neg, logic [127:0] mag);
        logic [127:0] v;
        if (!neg && mag > 128'h7fff_ffff) begin
            return {1'b1, 32'h7fff_ffff};
        end
        if (neg && mag > 128'h8000_0000) begin
            return {1'b1, 32'h8000_0000};
        end
        v = neg ? (128'd0 - mag) : mag;
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic [127:0] magnitude(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Expected result of one item; every part exact, truncated toward zero
    function automatic dual_res_t calc_dual_result(logic [135:0] d);
        logic [3:0]          cmd;
        logic signed [127:0] ar, ad, br, bd, t;
        logic                rn, dn;
        logic [127:0]        rm, dm;
        logic [32:0]         cr, cd;
        dual_res_t           r;
        cmd = d[3:0];
        ar = $signed(d[35:4]);
        ad = $signed(d[67:36]);
        br = $signed(d[99:68]);
        bd = $signed(d[131:100]);
        rn = 1'b0; rm = '0; dn = 1'b0; dm = '0;
        r = '0;
        case (cmd)
            dna_pkg::CMD_ADD: begin
                t = ar + br; rn = t < 0; rm = magnitude(t);
                t = ad + bd; dn = t < 0; dm = magnitude(t);
            end
            dna_pkg::CMD_SUB: begin
                t = ar - br; rn = t < 0; rm = magnitude(t);
                t = ad - bd; dn = t < 0; dm = magnitude(t);
            end
            dna_pkg::CMD_MUL: begin
                t = ar * br; rn = t < 0; rm = magnitude(t) >> FB;
                t = ad * br + ar * bd; dn = t < 0; dm = magnitude(t) >> FB;
            end
            dna_pkg::CMD_DIV: begin
                if (br == 0) begin
                    r.dz = 1'b1;
                end else begin
                    rn = (ar < 0) != (br < 0);
                    rm = (magnitude(ar) << FB) / magnitude(br);
                    t = ad * br - ar * bd;
                    dn = t < 0;
                    dm = (magnitude(t) << FB) / (br * br);
                end
            end
            dna_pkg::CMD_NEG: begin
                t = -ar; rn = t < 0; rm = magnitude(t);
                t = -ad; dn = t < 0; dm = magnitude(t);
            end
            dna_pkg::CMD_CONJ: begin
                rn = ar < 0; rm = magnitude(ar);
                t = -ad; dn = t < 0; dm = magnitude(t);
            end
            dna_pkg::CMD_INV: begin
                if (ar == 0) begin
                    r.dz = 1'b1;
                end else begin
                    rn = ar < 0;
                    rm = (128'd1 << (2 * FB)) / magnitude(ar);
                    dn = ad > 0;
                    dm = (magnitude(ad) << (2 * FB)) / (ar * ar);
                end
            end
            dna_pkg::CMD_MAG: begin
                rm = magnitude(ar);
            end
            dna_pkg::CMD_SQR: begin
                rm = (ar * ar) >> FB;
            end
            default: begin
            end
        endcase
        cr = clamp_part(rn, rm);
        cd = clamp_part(dn, dm);
        r.rr  = cr[31:0];
        r.rd  = cd[31:0];
        r.sat = cr[32] | cd[32];
        r.eq  = (ar == br) && (ad == bd);
        return r;
    endfunction

    assign pending = expected_q.size();

    // Record expectations on input accepts, compare on output accepts
    always @(posedge aclk) begin
        dual_res_t e, got;
        if (!aresetn) begin
            expected_q.delete();
            errors       <= 0;
            results_seen <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(calc_dual_result(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tuser[2]};
                if (expected_q.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    e = expected_q.pop_front();
                    if (got.rr !== e.rr || got.rd !== e.rd || got.dz !== e.dz ||
                        got.sat !== e.sat || got.eq !== e.eq) begin
                        errors <= errors + 1;
                        $display("%0t: mismatch real exp %h got %h, dual exp %h got %h",
                                 $time, e.rr, got.rr, e.rd, got.rd);
                        $display("%0t:   flags dz/sat/eq exp %b%b%b got %b%b%b", $time,
                                 e.dz, e.sat, e.eq, got.dz, got.sat, got.eq);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    int           errors;
    int           pending;
    int           results_seen;
    int           items_sent;
    bit           hold_done;

    dual_number_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    dna_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .results_seen(results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic [3:0] cmd, logic [31:0] ar, logic [31:0] ad,
                             logic [31:0] br, logic [31:0] bd);
        bit taken;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, bd, br, ad, ar, cmd};
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_tready;
        end
        items_sent++;
    endtask

    task automatic idle_cycles(int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    // Operand picker: extremes, zero, one, small and full-range values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4, 5: return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // Receiver: own stall pattern, with one long hold-off
    initial begin
        int cyc;
        int style;
        m_tready = 1'b0;
        cyc = 0;
        style = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 400 == 0) style = $urandom_range(0, 3);
            if (cyc >= 800 && cyc < 1100) begin
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            if (cyc == 1100) hold_done = 1'b1;
        end
    end

    initial begin
        logic [31:0] ar, ad, br, bd;
        logic [3:0]  cmd;
        s_tvalid = 1'b0;
        s_tdata = '0;
        aresetn = 1'b0;
        items_sent = 0;
        hold_done = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every command, extremes, zero divisors, equal operands
        send_item(dna_pkg::CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
        send_item(dna_pkg::CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_item(dna_pkg::CMD_SUB, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_item(dna_pkg::CMD_SUB, 32'h0003_0000, 32'h0001_8000, 32'h0003_0000, 32'h0001_8000);
        send_item(dna_pkg::CMD_MUL, 32'hffff_8000, 32'h0002_0000, 32'h0003_0000, 32'hfffe_0000);
        send_item(dna_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(dna_pkg::CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(dna_pkg::CMD_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_item(dna_pkg::CMD_DIV, 32'hfff9_0000, 32'h0001_0000, 32'h0003_0000, 32'hffff_0000);
        send_item(dna_pkg::CMD_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
        send_item(dna_pkg::CMD_DIV, 32'h0000_0001, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
        send_item(dna_pkg::CMD_NEG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_NEG, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h1);
        send_item(dna_pkg::CMD_CONJ, 32'hffff_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_INV, 32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_INV, 32'h0000_0001, 32'h7fff_ffff, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_INV, 32'hfffe_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_INV, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_MAG, 32'h8000_0000, 32'h1234_5678, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_MAG, 32'hfff0_0000, 32'h0, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_SQR, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
        send_item(dna_pkg::CMD_SQR, 32'hffff_8000, 32'h5, 32'h0, 32'h0);
        send_item(4'd9, 32'h1, 32'h2, 32'h1, 32'h2);
        send_item(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0);

        // Drain fully before the random part
        idle_cycles(1);
        while (pending != 0) @(negedge aclk);

        // Random part: bursts and gaps; keeps offering across the long hold-off
        while (items_sent < 1625 || !hold_done) begin
            cmd = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            ar = pick_word();
            ad = pick_word();
            br = pick_word();
            bd = pick_word();
            case ($urandom_range(0, 15))
                0: begin br = ar; bd = ad; end
                1: br = 32'd0;
                2: ar = 32'd0;
                default: begin end
            endcase
            send_item(cmd, ar, ad, br, bd);
            if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(1, 12));
        end
        idle_cycles(1);

        // Drain and let the pipeline settle
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        $display("Sent %0d items over all nine commands and unused codes; %0d results checked",
                 items_sent, results_seen);
        $display("Covered saturation, zero divisors, equality and output stalls");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Overall time limit
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
